FILE: rtl/core/efr_pkg.sv
// Shared types and constants for the escaped frame receiver.
// Used by efr_ctrl, efr_dp and escaped_frame_receiver; no dependencies.
package efr_pkg;

  // Payload store geometry
  localparam int unsigned MaxPayload = 64;
  localparam int unsigned AddrW      = 6;   // index into the payload store
  localparam int unsigned CountW     = 7;   // 0..MaxPayload
  localparam int unsigned LenW       = 16;  // declared length on the wire

  // Special bytes of the framing
  localparam logic [7:0] DelimByte = 8'h7E;
  localparam logic [7:0] EscByte   = 8'h7D;
  localparam logic [7:0] XonByte   = 8'h11;
  localparam logic [7:0] XoffByte  = 8'h13;
  localparam logic [7:0] EscMask   = 8'h20;
  localparam logic [7:0] CsumGood  = 8'hFF;

  // Controller phases
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELIM,
    ST_MSB,
    ST_MSB_ESC,
    ST_LSB,
    ST_LSB_ESC,
    ST_DATA,
    ST_DATA_ESC,
    ST_CRC_ESC,
    ST_RD,
    ST_OUT
  } efr_state_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic unesc;       // apply escape XOR to the received byte
    logic clr_frame;   // clear byte count and running sum
    logic ld_msb;      // load length MSB, clear LSB
    logic ld_lsb;      // load length LSB
    logic store;       // write payload byte, bump count and sum
    logic drain_start; // reset the read index
    logic rd_en;       // read payload store at the read index
    logic idx_inc;     // advance the read index
  } efr_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic is_flow;     // XON / XOFF byte
    logic is_delim;    // frame delimiter
    logic is_esc;      // escape byte
    logic len_over;    // declared length exceeds the store
    logic len_zero;    // declared length is zero
    logic count_eq;    // all declared payload bytes stored
    logic csum_ok;     // checksum of current byte matches
    logic last_idx;    // read index is on the final result
  } efr_sts_t;

endpackage

FILE: rtl/core/efr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module efr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/core/efr_dp.sv
// Datapath of the escaped frame receiver: byte decode, length, count,
// checksum, payload store and read index. Depends on efr_pkg and efr_ram.
module efr_dp import efr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        rx_byte_i,
  input  efr_cmd_t          cmd_i,
  output efr_sts_t          sts_o,
  output logic [7:0]        payload_byte_o,
  output logic [AddrW-1:0]  byte_index_o,
  output logic [CountW-1:0] frame_length_o
);

  logic [LenW-1:0]   decl_len_q, decl_len_d;
  logic [CountW-1:0] count_q, count_d;
  logic [7:0]        sum_q, sum_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [7:0]        byte_val;
  logic              wr_en;
  logic [7:0]        rd_data;
  logic [CountW-1:0] idx_next;

  // Unescaped byte value
  assign byte_val = cmd_i.unesc ? (rx_byte_i ^ EscMask) : rx_byte_i;

  // Store only while room is left
  assign wr_en = cmd_i.store && (count_q < CountW'(MaxPayload));

  always_comb begin
    decl_len_d = decl_len_q;
    count_d    = count_q;
    sum_d      = sum_q;
    idx_d      = idx_q;
    if (cmd_i.ld_msb) begin
      decl_len_d = {byte_val, 8'h00};
    end
    if (cmd_i.ld_lsb) begin
      decl_len_d = {decl_len_q[LenW-1:8], byte_val};
    end
    if (cmd_i.clr_frame) begin
      count_d = '0;
      sum_d   = '0;
    end
    if (wr_en) begin
      count_d = count_q + CountW'(1);
      sum_d   = sum_q + byte_val;
    end
    if (cmd_i.drain_start) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decl_len_q <= '0;
      count_q    <= '0;
      sum_q      <= '0;
      idx_q      <= '0;
    end else begin
      decl_len_q <= decl_len_d;
      count_q    <= count_d;
      sum_q      <= sum_d;
      idx_q      <= idx_d;
    end
  end

  // Payload store
  efr_ram #(
    .Width (8),
    .Depth (MaxPayload)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[AddrW-1:0]),
    .wr_data_i (byte_val),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_data)
  );

  // Status toward the controller
  assign idx_next = {1'b0, idx_q} + CountW'(1);

  always_comb begin
    sts_o.is_flow  = (rx_byte_i == XonByte) || (rx_byte_i == XoffByte);
    sts_o.is_delim = (rx_byte_i == DelimByte);
    sts_o.is_esc   = (rx_byte_i == EscByte);
    sts_o.len_over = decl_len_q > LenW'(MaxPayload);
    sts_o.len_zero = (decl_len_q == '0);
    sts_o.count_eq = ({{(LenW-CountW){1'b0}}, count_q} == decl_len_q);
    sts_o.csum_ok  = ((sum_q + byte_val) == CsumGood);
    sts_o.last_idx = (count_q == '0) || (idx_next == count_q);
  end

  // Result fields; an empty frame shows a zero byte
  assign payload_byte_o = (count_q == '0) ? 8'h00 : rd_data;
  assign byte_index_o   = idx_q;
  assign frame_length_o = count_q;

endmodule

FILE: rtl/core/efr_ctrl.sv
// Controller of the escaped frame receiver: frame parsing phases and
// payload drain sequence. Depends on efr_pkg.
module efr_ctrl import efr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     rx_valid_i,
  output logic     rx_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  efr_sts_t sts_i,
  output efr_cmd_t cmd_o,
  output logic     last_o
);

  efr_state_e state_q, state_d;
  logic       acc;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign acc = rx_valid_i && rx_ready_o;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    rx_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    last_o      = sts_i.last_idx;
    cmd_o.unesc = (state_q == ST_MSB_ESC) || (state_q == ST_LSB_ESC) ||
                  (state_q == ST_DATA_ESC) || (state_q == ST_CRC_ESC);

    unique case (state_q)
      ST_IDLE: begin
        rx_ready_o = 1'b1;
        if (acc && sts_i.is_delim) begin
          state_d = ST_DELIM;
        end
      end
      ST_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.last_idx) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_RD;
          end
        end
      end
      default: begin
        // Frame phases: flow bytes abort, delimiter restarts
        rx_ready_o = 1'b1;
        if (acc) begin
          if (sts_i.is_flow) begin
            state_d = ST_IDLE;
          end else if (sts_i.is_delim) begin
            state_d = ST_DELIM;
          end else begin
            unique case (state_q)
              ST_DELIM: begin
                cmd_o.clr_frame = 1'b1;
                if (sts_i.is_esc) begin
                  state_d = ST_MSB_ESC;
                end else begin
                  cmd_o.ld_msb = 1'b1;
                  state_d      = ST_MSB;
                end
              end
              ST_MSB_ESC: begin
                if (sts_i.is_esc) begin
                  state_d = ST_IDLE;
                end else begin
                  cmd_o.ld_msb = 1'b1;
                  state_d      = ST_MSB;
                end
              end
              ST_MSB: begin
                if (sts_i.is_esc) begin
                  state_d = ST_LSB_ESC;
                end else begin
                  cmd_o.ld_lsb = 1'b1;
                  state_d      = ST_LSB;
                end
              end
              ST_LSB_ESC: begin
                if (sts_i.is_esc) begin
                  state_d = ST_IDLE;
                end else begin
                  cmd_o.ld_lsb = 1'b1;
                  state_d      = ST_LSB;
                end
              end
              ST_LSB: begin
                if (sts_i.len_over) begin
                  state_d = ST_IDLE;
                end else if (sts_i.len_zero) begin
                  // Empty frame: this byte is the checksum
                  if (sts_i.is_esc) begin
                    state_d = ST_CRC_ESC;
                  end else begin
                    cmd_o.drain_start = sts_i.csum_ok;
                    state_d           = sts_i.csum_ok ? ST_RD : ST_IDLE;
                  end
                end else if (sts_i.is_esc) begin
                  state_d = ST_DATA_ESC;
                end else begin
                  cmd_o.store = 1'b1;
                  state_d     = ST_DATA;
                end
              end
              ST_DATA_ESC: begin
                if (sts_i.is_esc) begin
                  state_d = ST_IDLE;
                end else begin
                  cmd_o.store = 1'b1;
                  state_d     = ST_DATA;
                end
              end
              ST_DATA: begin
                if (sts_i.is_esc) begin
                  state_d = sts_i.count_eq ? ST_CRC_ESC : ST_DATA_ESC;
                end else if (!sts_i.count_eq) begin
                  cmd_o.store = 1'b1;
                end else begin
                  cmd_o.drain_start = sts_i.csum_ok;
                  state_d           = sts_i.csum_ok ? ST_RD : ST_IDLE;
                end
              end
              ST_CRC_ESC: begin
                if (sts_i.is_esc) begin
                  state_d = ST_IDLE;
                end else begin
                  cmd_o.drain_start = sts_i.csum_ok;
                  state_d           = sts_i.csum_ok ? ST_RD : ST_IDLE;
                end
              end
              default: begin
                state_d = ST_IDLE;
              end
            endcase
          end
        end
      end
    endcase
  end

endmodule

FILE: rtl/core/escaped_frame_receiver.sv
// Top level of the escaped frame receiver.
// Depends on efr_pkg, efr_ctrl, efr_dp (which holds efr_ram).
//
// Usage:
//   Raw serial bytes enter on the rx channel (rx_valid_i / rx_ready_o,
//   rx_byte_i), one request per byte. Frames are 0x7E, a 16-bit length,
//   the escaped payload and a checksum. While a frame is being parsed the
//   block takes one byte per cycle.
//   When the checksum byte matches, the stored payload leaves on the out
//   channel (out_valid_o / out_ready_i) one result per byte, with last_o on
//   the final one; an empty frame gives a single zero result with last_o.
//   Each result is read from the payload store (ST_RD) and then presented
//   (ST_OUT); the next read starts only after the one before is taken.
//   rx_ready_o is low during the drain, so a stalled receiver holds off
//   new input until the last result is taken. A bad frame emits nothing.
//   Reset returns the parser to idle and clears length, count and sum;
//   the payload store is not cleared and needs no setup.
module escaped_frame_receiver import efr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rx_valid_i,
  output logic              rx_ready_o,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        payload_byte_o,
  output logic [AddrW-1:0]  byte_index_o,
  output logic [CountW-1:0] frame_length_o,
  output logic              last_o
);

  efr_cmd_t cmd;
  efr_sts_t sts;

  // Frame parser and drain sequencer
  efr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid_i),
    .rx_ready_o  (rx_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .last_o      (last_o)
  );

  // Length, checksum and payload store
  efr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_byte_i      (rx_byte_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .payload_byte_o (payload_byte_o),
    .byte_index_o   (byte_index_o),
    .frame_length_o (frame_length_o)
  );

`ifndef ASSERT_OFF
  // Input is never taken while a result is on offer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rx_ready_o && out_valid_o))
    else $error("rx_ready and out_valid both high");

  // The final result sits on the last stored byte, or marks an empty frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |->
      ((frame_length_o == '0) ||
       ({1'b0, byte_index_o} + CountW'(1) == frame_length_o)))
    else $error("last result not on final byte");

  // A verified frame never reports more bytes than the store holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_length_o <= CountW'(MaxPayload)))
    else $error("frame length beyond store size");

  // A result taken without last is followed by a read cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> (!out_valid_o && !rx_ready_o))
    else $error("drain sequence broken");
`endif

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for escaped_frame_receiver: raw serial bytes in, verified payload out.
// Depends on efr_pkg and the escaped_frame_receiver RTL; the expected payload is predicted in-line.
module testbench;
  import efr_pkg::*;

  localparam int StallLimit = 1000;  // cycles without any handshake before giving up
  localparam int RandItems  = 130;
  localparam int CalmTail   = 40;    // last requests go out with no idling on either side

  typedef struct {
    logic [7:0] b;
    bit         hold;  // wait until every pending payload byte has come out
  } rx_req_t;

  typedef struct packed {
    logic [7:0]        data;
    logic [AddrW-1:0]  idx;
    logic [CountW-1:0] len;
    logic              last;
  } frame_byte_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              rx_valid_i     = 1'b0;
  logic              rx_ready_o;
  logic [7:0]        rx_byte_i      = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [7:0]        payload_byte_o;
  logic [AddrW-1:0]  byte_index_o;
  logic [CountW-1:0] frame_length_o;
  logic              last_o;

  rx_req_t     pending_q[$];
  frame_byte_t verified_bytes_q[$];
  int          fail_count  = 0;
  int          rx_gap      = 0;
  int          out_stall   = 0;
  int          idle_cycles = 0;
  logic        calm        = 1'b0;

  // Parser mirror
  efr_state_e        rx_ph    = ST_IDLE;
  logic [LenW-1:0]   decl_len = '0;
  logic [CountW-1:0] got_cnt  = '0;
  logic [7:0]        csum_acc = '0;
  logic [7:0]        payload_mem [MaxPayload];

  escaped_frame_receiver u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_valid_i    (rx_valid_i),
    .rx_ready_o    (rx_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .payload_byte_o(payload_byte_o),
    .byte_index_o  (byte_index_o),
    .frame_length_o(frame_length_o),
    .last_o        (last_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void keep_byte(input logic [7:0] b);
    if (got_cnt < MaxPayload) begin
      payload_mem[got_cnt[AddrW-1:0]] = b;
      got_cnt  = got_cnt + 1'b1;
      csum_acc = csum_acc + b;
    end
  endfunction

  // Checksum byte seen: queue the payload burst on a match, go idle either way
  function automatic void close_frame(input logic [7:0] csum);
    frame_byte_t r;
    int k;
    rx_ph = ST_IDLE;
    if (8'(CsumGood - csum_acc) != csum) return;
    if (got_cnt == 0) begin
      r.data = '0;
      r.idx  = '0;
      r.len  = '0;
      r.last = 1'b1;
      verified_bytes_q.push_back(r);
      return;
    end
    for (k = 0; k < int'(got_cnt); k++) begin
      r.data = payload_mem[k];
      r.idx  = AddrW'(k);
      r.len  = got_cnt;
      r.last = (k + 1 == int'(got_cnt));
      verified_bytes_q.push_back(r);
    end
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    if (rx_ph == ST_IDLE) begin
      if (b == DelimByte) rx_ph = ST_DELIM;
    end else if (b == XonByte || b == XoffByte) begin
      rx_ph = ST_IDLE;
    end else if (b == DelimByte) begin
      rx_ph = ST_DELIM;
    end else begin
      case (rx_ph)
        ST_DELIM: begin
          got_cnt  = '0;
          csum_acc = '0;
          if (b == EscByte) begin
            rx_ph = ST_MSB_ESC;
          end else begin
            decl_len = {b, 8'h00};
            rx_ph    = ST_MSB;
          end
        end
        ST_MSB_ESC: begin
          if (b == EscByte) begin
            rx_ph = ST_IDLE;
          end else begin
            decl_len = {b ^ EscMask, 8'h00};
            rx_ph    = ST_MSB;
          end
        end
        ST_MSB: begin
          if (b == EscByte) begin
            rx_ph = ST_LSB_ESC;
          end else begin
            decl_len = decl_len + b;
            rx_ph    = ST_LSB;
          end
        end
        ST_LSB_ESC: begin
          if (b == EscByte) begin
            rx_ph = ST_IDLE;
          end else begin
            decl_len = decl_len + 8'(b ^ EscMask);
            rx_ph    = ST_LSB;
          end
        end
        ST_LSB: begin
          if (decl_len > MaxPayload) begin
            rx_ph = ST_IDLE;
          end else if (decl_len == 0) begin
            // empty frame: this byte is already the checksum
            if (b == EscByte) rx_ph = ST_CRC_ESC;
            else close_frame(b);
          end else if (b == EscByte) begin
            rx_ph = ST_DATA_ESC;
          end else begin
            keep_byte(b);
            rx_ph = ST_DATA;
          end
        end
        ST_DATA_ESC: begin
          if (b == EscByte) begin
            rx_ph = ST_IDLE;
          end else begin
            keep_byte(b ^ EscMask);
            rx_ph = ST_DATA;
          end
        end
        ST_DATA: begin
          if (b == EscByte) begin
            rx_ph = (got_cnt != decl_len) ? ST_DATA_ESC : ST_CRC_ESC;
          end else if (got_cnt != decl_len) begin
            keep_byte(b);
          end else begin
            close_frame(b);
          end
        end
        ST_CRC_ESC: begin
          if (b == EscByte) rx_ph = ST_IDLE;
          else close_frame(b ^ EscMask);
        end
        default: rx_ph = ST_IDLE;
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  function automatic bit is_special(input logic [7:0] b);
    return b == DelimByte || b == EscByte || b == XonByte || b == XoffByte;
  endfunction

  task automatic put_byte(input logic [7:0] b);
    rx_req_t r;
    r.b    = b;
    r.hold = 1'b0;
    pending_q.push_back(r);
  endtask

  // Escape specials always, and now and then a plain byte whose escaped form is harmless
  task automatic put_escaped(input logic [7:0] b);
    if (is_special(b) || (!is_special(b ^ EscMask) && $urandom_range(0, 9) == 0)) begin
      put_byte(EscByte);
      put_byte(b ^ EscMask);
    end else begin
      put_byte(b);
    end
  endtask

  // Well-formed frame of len bytes; csum_flip != 0 spoils the checksum
  task automatic put_frame(input logic [15:0] len, input logic [7:0] csum_flip);
    logic [7:0] data;
    logic [7:0] sum;
    int i;
    sum = '0;
    put_byte(DelimByte);
    put_escaped(len[15:8]);
    put_escaped(len[7:0]);
    for (i = 0; i < int'(len); i++) begin
      case ($urandom_range(0, 7))
        0:       data = DelimByte;
        1:       data = EscByte;
        2:       data = XonByte;
        3:       data = XoffByte;
        default: data = 8'($urandom_range(0, 255));
      endcase
      sum = sum + data;
      put_escaped(data);
    end
    put_escaped(8'(CsumGood - sum) ^ csum_flip);
  endtask

  // Drop the tail of the frame that starts at index first
  task automatic cut_frame(input int first);
    int cut;
    cut = $urandom_range(first + 1, pending_q.size() - 1);
    while (pending_q.size() > cut) void'(pending_q.pop_back());
  endtask

  function automatic logic [15:0] small_len();
    if ($urandom_range(0, 19) == 0) return 16'($urandom_range(11, 63));
    return 16'($urandom_range(0, 10));
  endfunction

  task automatic build_stimulus();
    int         start;
    int         kind;
    int         body_items;
    int         i;
    bit         full_done;
    bit         first;
    logic [15:0] len;
    logic [7:0]  b;
    body_items = 0;
    full_done  = 1'b0;
    first      = 1'b1;

    // Directed: idle noise, empty frame, escaped length and data, empty frame with
    // escaped checksum, oversized length
    put_byte(8'h00); put_byte(8'hFF); put_byte(XonByte);
    put_byte(DelimByte); put_byte(8'h00); put_byte(8'h00); put_byte(8'hFF);
    put_byte(DelimByte); put_byte(EscByte); put_byte(8'h20); put_byte(EscByte);
    put_byte(8'h22); put_byte(EscByte); put_byte(8'h5D); put_byte(EscByte);
    put_byte(8'h31); put_byte(8'h71);
    put_byte(DelimByte); put_byte(8'h00); put_byte(8'h00); put_byte(EscByte);
    put_byte(8'hDF);
    put_byte(DelimByte); put_byte(8'h00); put_byte(8'h41); put_byte(8'h00);

    // Random: mostly good frames, the rest broken ones and line noise
    while (body_items < RandItems) begin
      start = pending_q.size();
      kind  = $urandom_range(0, 99);
      if (kind < 70) begin
        if (!full_done && body_items >= 50) begin
          len       = 16'(MaxPayload);
          full_done = 1'b1;
        end else begin
          len = small_len();
        end
        put_frame(len, 8'h00);
      end else if (kind < 76) begin
        put_frame(small_len(), 8'($urandom_range(1, 255)));
      end else if (kind < 81) begin
        // flow control byte mid-frame
        put_frame(small_len(), 8'h00);
        cut_frame(start);
        put_byte($urandom_range(0, 1) ? XonByte : XoffByte);
      end else if (kind < 85) begin
        // delimiter mid-frame
        put_frame(small_len(), 8'h00);
        cut_frame(start);
        put_byte(DelimByte);
      end else if (kind < 90) begin
        // bad escape
        put_frame(small_len(), 8'h00);
        cut_frame(start);
        put_byte(EscByte);
        case ($urandom_range(0, 3))
          0:       put_byte(EscByte);
          1:       put_byte(XonByte);
          2:       put_byte(XoffByte);
          default: put_byte(DelimByte);
        endcase
      end else if (kind < 95) begin
        // length beyond the store
        len = 16'($urandom_range(MaxPayload + 1, 16'hFFFF));
        put_byte(DelimByte);
        put_escaped(len[15:8]);
        put_escaped(len[7:0]);
        for (i = 0; i < $urandom_range(1, 3); i++) put_escaped(8'($urandom_range(0, 255)));
      end else begin
        for (i = 0; i < $urandom_range(1, 3); i++) begin
          b = 8'($urandom_range(0, 255));
          put_byte(b == DelimByte ? 8'h00 : b);
        end
      end
      if (kind < 95) begin
        body_items += pending_q.size() - start;
        if (first || $urandom_range(0, 19) == 0) pending_q[start].hold = 1'b1;
        first = 1'b0;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: rx requests
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_valid_i <= 1'b0;
      rx_byte_i  <= '0;
      rx_gap      = 0;
    end else begin
      if (rx_valid_i && rx_ready_o) begin
        parse_rx_byte(rx_byte_i);
        if (!calm && $urandom_range(0, 99) < 15) rx_gap = $urandom_range(1, 3);
      end
      if (!rx_valid_i || rx_ready_o) begin
        if (rx_gap > 0) begin
          rx_gap      = rx_gap - 1;
          rx_valid_i <= 1'b0;
        end else if (pending_q.size() > 0 &&
                     (!pending_q[0].hold || verified_bytes_q.size() == 0)) begin
          rx_valid_i <= 1'b1;
          rx_byte_i  <= pending_q[0].b;
          void'(pending_q.pop_front());
        end else begin
          rx_valid_i <= 1'b0;
        end
      end
      calm <= (pending_q.size() < CalmTail);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result with the oldest expected payload byte
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    frame_byte_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall    = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (verified_bytes_q.size() == 0) begin
          $error("unexpected result: payload_byte %0h byte_index %0d", payload_byte_o,
                 byte_index_o);
          fail_count++;
        end else begin
          want = verified_bytes_q.pop_front();
          if (payload_byte_o !== want.data) begin
            $error("payload_byte: expected %0h, got %0h", want.data, payload_byte_o);
            fail_count++;
          end
          if (byte_index_o !== want.idx) begin
            $error("byte_index: expected %0d, got %0d", want.idx, byte_index_o);
            fail_count++;
          end
          if (frame_length_o !== want.len) begin
            $error("frame_length: expected %0d, got %0d", want.len, frame_length_o);
            fail_count++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_o);
            fail_count++;
          end
        end
      end
      if (out_stall == 0 && !calm && $urandom_range(0, 99) < 20) out_stall = $urandom_range(1, 3);
      if (out_stall > 0) begin
        out_stall    = out_stall - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rx_valid_i && rx_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Reset, stimulus and end of run
  initial begin
    build_stimulus();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (pending_q.size() != 0 || rx_valid_i);
    while (verified_bytes_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/efr_pkg.sv
rtl/core/efr_ram.sv
rtl/core/efr_dp.sv
rtl/core/efr_ctrl.sv
rtl/core/escaped_frame_receiver.sv
tb/sv/testbench.sv
